// File: rtl/core/assert_macros.svh
// Assertion shorthands shared by the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/dksm_pkg.sv
package dksm_pkg;

    localparam int MAX_ORDER  = 1024;
    localparam int IDX_W      = $clog2(MAX_ORDER);
    localparam int K_W        = $clog2(MAX_ORDER + 1);
    localparam int ORD_W      = 11;
    localparam int WORD_W     = 31;
    localparam int VAR_W      = 2;
    localparam int SEED_IDX_W = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int PROD_W     = 2 * WORD_W + 1;
    localparam int ACC_W      = 64;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS     = ACC_W / DIGIT_W;
    localparam int CNT_W      = $clog2(DIGITS);

    localparam logic [VAR_W-1:0] VARIANT_SUM = VAR_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER,
        REG_MULT,
        REG_MOD,
        REG_VARIANT
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } cmd_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

endpackage

// File: rtl/core/dksm_ring_mem.sv
module dksm_ring_mem (
    input  logic                           clk,
    input  dksm_pkg::ram_req_t             req,
    output logic [dksm_pkg::WORD_W-1:0]    rdata
);
    import dksm_pkg::*;

    logic [WORD_W-1:0] mem [MAX_ORDER];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// File: rtl/core/dksm_mod_reduce.sv
module dksm_mod_reduce (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dksm_pkg::ACC_W-1:0]    dividend,
    input  logic [dksm_pkg::WORD_W-1:0]   modulus,
    output logic                          done,
    output logic [dksm_pkg::WORD_W-1:0]   remainder
);
    import dksm_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ACC_W-1:0]  shift_reg;
    logic [WORD_W-1:0] mod_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;

    // Shift in one digit per cycle; each bit does one compare and subtract.
    always_comb
    begin
        logic [WORD_W:0] trial;
        rem_next = rem_reg;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            trial = {rem_next, shift_reg[ACC_W-1-i]};
            if (trial >= {1'b0, mod_reg})
            begin
                trial = trial - {1'b0, mod_reg};
            end
            rem_next = trial[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= '0;
            shift_reg <= dividend;
            mod_reg   <= modulus;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_reg << DIGIT_W;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/dx_k_s_mrg_generator_core.sv
// DX-k-s multiple recursive generator. The history ring of past values lives
// in a single-port-read, single-port-write synchronous RAM of MAX_ORDER
// words. A load word writes one seed into the ring in the cycle it is
// accepted and produces no result; seed_index values at or beyond MAX_ORDER
// are dropped. A step word advances the running position (wrapping at the
// order clamped to 2..MAX_ORDER), reads the oldest and the newest entries
// through the one RAM read port on consecutive cycles, forms
// B*oldest + newest (any variant but 2) or B*(oldest + newest) (variant 2)
// with one registered 31x32 multiply, reduces that modulo p (0 and 1 act as
// 2) with an iterative remainder unit that retires four bits per cycle,
// writes the result back over the oldest entry and presents it on value.
// A load leaves the block idle for the next word. A step runs from
// acceptance through the reads, the multiply and the remainder loop to the
// result word, and the next word is accepted once the result is loaded
// into value, even while it waits to be taken. A step whose result finds
// the previous word still waiting holds in delivery until that word leaves.
// Ring entries have no reset and read as garbage until written, so load
// every position the recurrence will touch before stepping. There is no
// clearing pass. Write configuration registers only while the block is idle.

`include "assert_macros.svh"

module dx_k_s_mrg_generator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              cfg_we,
    input  logic [dksm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dksm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input words
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [dksm_pkg::SEED_IDX_W-1:0]   seed_index,
    input  logic [dksm_pkg::WORD_W-1:0]       seed_value,
    // result words
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [dksm_pkg::WORD_W-1:0]       value
);
    import dksm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_NEW,
        S_MUL,
        S_START,
        S_REDUCE,
        S_DELIVER
    } state_t;

    // Configuration registers.
    logic [ORD_W-1:0]  order_reg;
    logic [WORD_W-1:0] mult_reg;
    logic [WORD_W-1:0] modulus_reg;
    logic [VAR_W-1:0]  variant_reg;

    // Control and datapath registers.
    state_t            state_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  prev_reg;
    logic [WORD_W-1:0] oldest_reg;
    logic [PROD_W-1:0] product_reg;
    logic [WORD_W-1:0] addend_reg;
    logic [WORD_W-1:0] result_reg;
    logic [WORD_W-1:0] mod_eff_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] value_reg;

    // Combinational helpers.
    logic [K_W-1:0]    k_eff;
    logic [WORD_W-1:0] mod_eff;
    logic [IDX_W:0]    pos_inc;
    logic [IDX_W-1:0]  pos_wrap;
    logic              in_acc;
    logic              step_acc;
    logic              load_acc;
    logic              load_ok;
    logic              out_free;
    logic              out_load;
    logic [WORD_W:0]   mul_op;
    ram_req_t          ram_req;
    logic [WORD_W-1:0] ram_rdata;
    logic              mod_start;
    logic              mod_done;
    logic [WORD_W-1:0] mod_rem;
    logic [ACC_W-1:0]  dividend;

    // Clamp order to 2..MAX_ORDER, modulus to at least 2.
    always_comb
    begin
        if (order_reg < ORD_W'(2))
        begin
            k_eff = K_W'(2);
        end
        else if (32'(order_reg) > 32'(MAX_ORDER))
        begin
            k_eff = K_W'(MAX_ORDER);
        end
        else
        begin
            k_eff = K_W'(order_reg);
        end
    end

    assign mod_eff = (modulus_reg < WORD_W'(2)) ? WORD_W'(2) : modulus_reg;

    // Advance the running position; wrap when it reaches the order.
    assign pos_inc  = {1'b0, pos_reg} + (IDX_W+1)'(1);
    assign pos_wrap = (32'(pos_inc) >= 32'(k_eff)) ? '0 : pos_inc[IDX_W-1:0];

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign step_acc = in_acc && (command == CMD_STEP);
    assign load_acc = in_acc && (command == CMD_LOAD);
    assign load_ok  = 32'(seed_index) < 32'(MAX_ORDER);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_DELIVER) && out_free;

    // Multiplier operand: oldest alone, or oldest plus newest.
    assign mul_op = (variant_reg == VARIANT_SUM)
                  ? ({1'b0, oldest_reg} + {1'b0, ram_rdata})
                  : {1'b0, oldest_reg};

    assign mod_start = (state_reg == S_START);
    assign dividend  = ACC_W'(product_reg) + ACC_W'(addend_reg);

    // RAM port: seed writes and result write-back share the write side;
    // the two history reads go through the read side on separate cycles.
    always_comb
    begin
        ram_req       = '0;
        ram_req.we    = (load_acc && load_ok) || out_load;
        ram_req.waddr = out_load ? pos_reg : IDX_W'(seed_index);
        ram_req.wdata = out_load ? result_reg : seed_value;
        ram_req.re    = step_acc || (state_reg == S_RD_NEW);
        ram_req.raddr = (state_reg == S_RD_NEW) ? prev_reg : pos_wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg   <= ORD_W'(2);
            mult_reg    <= WORD_W'(1);
            modulus_reg <= WORD_W'(2147483647);
            variant_reg <= VAR_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORDER:   order_reg   <= cfg_data[ORD_W-1:0];
                REG_MULT:    mult_reg    <= cfg_data[WORD_W-1:0];
                REG_MOD:     modulus_reg <= cfg_data[WORD_W-1:0];
                REG_VARIANT: variant_reg <= cfg_data[VAR_W-1:0];
                default:     ;
            endcase
        end
    end

    // Step sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            prev_reg      <= '0;
            oldest_reg    <= '0;
            product_reg   <= '0;
            addend_reg    <= '0;
            mod_eff_reg   <= '0;
            result_reg    <= '0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a new result word, or drop the one that just left.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (step_acc)
                    begin
                        prev_reg  <= pos_reg;
                        pos_reg   <= pos_wrap;
                        state_reg <= S_RD_NEW;
                    end
                end
                S_RD_NEW:
                begin
                    oldest_reg <= ram_rdata;
                    state_reg  <= S_MUL;
                end
                S_MUL:
                begin
                    product_reg <= PROD_W'(mult_reg) * PROD_W'(mul_op);
                    addend_reg  <= (variant_reg == VARIANT_SUM) ? '0 : ram_rdata;
                    mod_eff_reg <= mod_eff;
                    state_reg   <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_REDUCE;
                end
                S_REDUCE:
                begin
                    if (mod_done)
                    begin
                        result_reg <= mod_rem;
                        state_reg  <= S_DELIVER;
                    end
                end
                S_DELIVER:
                begin
                    if (out_free)
                    begin
                        value_reg <= result_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    dksm_ring_mem u_ring (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    dksm_mod_reduce u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (dividend),
        .modulus   (mod_eff_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    // A step always walks into the history read and lands inside the ring.
    `ASSERT_NEXT(a_step_reads, clk, rst_n, step_acc, state_reg == S_RD_NEW)
    `ASSERT_NEXT(a_pos_in_ring, clk, rst_n, step_acc, 32'(pos_reg) < 32'(k_eff))
    // The remainder unit only finishes while the sequencer waits for it.
    `ASSERT_IMPLIES(a_done_in_reduce, clk, rst_n, mod_done, state_reg == S_REDUCE)
    // Every delivered word is fully reduced.
    `ASSERT_NEXT(a_value_reduced, clk, rst_n, out_load, value_reg < mod_eff_reg)

endmodule

// File: tb/sv/dx_k_s_mrg_result_checker.sv
`timescale 1ns / 1ps

module dx_k_s_mrg_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dksm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dksm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              command,
    input  logic [dksm_pkg::SEED_IDX_W-1:0]   seed_index,
    input  logic [dksm_pkg::WORD_W-1:0]       seed_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [dksm_pkg::WORD_W-1:0]       value,
    output int unsigned                       fail_count,
    output int unsigned                       pending
);
    import dksm_pkg::*;

    logic [WORD_W-1:0] history_words [MAX_ORDER];
    int unsigned       newest_slot;
    logic [ORD_W-1:0]  order_reg;
    logic [WORD_W-1:0] mult_reg;
    logic [WORD_W-1:0] mod_reg;
    logic [VAR_W-1:0]  variant_reg;
    logic [WORD_W-1:0] generated_values [$];

    // Next value of the recurrence, exact in 64 bits before the reduction.
    function automatic logic [WORD_W-1:0] next_value(input logic [WORD_W-1:0] oldest,
                                                     input logic [WORD_W-1:0] newest);
        logic [63:0] acc;
        logic [63:0] p;
        p = (mod_reg < 2) ? 64'd2 : 64'(mod_reg);
        if (variant_reg == VARIANT_SUM)
            acc = 64'(mult_reg) * (64'(oldest) + 64'(newest));
        else
            acc = 64'(mult_reg) * 64'(oldest) + 64'(newest);
        return WORD_W'(acc % p);
    endfunction

    function automatic void report_failure(input string what,
                                           input logic [WORD_W-1:0] want,
                                           input logic [WORD_W-1:0] got);
        if (fail_count < 10)
            $display("%t: %s: expected %h, got %h", $realtime, what, want, got);
        fail_count++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        int unsigned       span;
        int unsigned       prev_slot;
        int unsigned       next_slot;
        logic [WORD_W-1:0] want;
        if (!rst_n)
        begin
            generated_values.delete();
            newest_slot = 0;
            order_reg   = ORD_W'(2);
            mult_reg    = WORD_W'(1);
            mod_reg     = WORD_W'(2147483647);
            variant_reg = VAR_W'(1);
            fail_count  = 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ORDER:   order_reg   = cfg_data[ORD_W-1:0];
                    REG_MULT:    mult_reg    = cfg_data;
                    REG_MOD:     mod_reg     = cfg_data;
                    REG_VARIANT: variant_reg = cfg_data[VAR_W-1:0];
                    default: ;
                endcase
            end

            // retire results before taking new words: a result leaving at this
            // edge belongs to an earlier step
            if (out_valid && !out_stall)
            begin
                if (generated_values.size() == 0)
                    report_failure("result word with nothing expected", 'x, value);
                else
                begin
                    want = generated_values.pop_front();
                    if (value !== want)
                        report_failure("value mismatch", want, value);
                end
            end

            if (in_valid && !in_stall)
            begin
                if (command == CMD_LOAD)
                    history_words[seed_index] = seed_value;
                else
                begin
                    span = (order_reg < 2) ? 2
                         : (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
                    prev_slot = newest_slot;
                    next_slot = prev_slot + 1;
                    if (next_slot >= span)
                        next_slot = 0;
                    want = next_value(history_words[next_slot], history_words[prev_slot]);
                    history_words[next_slot] = want;
                    newest_slot = next_slot;
                    generated_values.push_back(want);
                end
            end

            pending <= generated_values.size();
        end
    end

endmodule

// File: tb/sv/dx_k_s_mrg_generator_core_tb.sv
`timescale 1ns / 1ps

module dx_k_s_mrg_generator_core_tb;
    import dksm_pkg::*;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_ORDER;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    logic                  command    = CMD_LOAD;
    logic [SEED_IDX_W-1:0] seed_index = '0;
    logic [WORD_W-1:0]     seed_value = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [WORD_W-1:0]     value;

    int unsigned fail_count;
    int unsigned pending;

    // Stimulus-side bookkeeping: which ring slots hold a defined word, where the
    // running position sits and how far it wraps. Used only to keep steps
    // from reading a slot that was never written.
    bit          seeded [MAX_ORDER];
    int unsigned cursor    = 0;
    int unsigned ring_span = 2;
    // Set for the last phase: no idling on either side.
    bit          calm      = 1'b0;

    always #5 clk = ~clk;

    dx_k_s_mrg_generator_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .seed_index (seed_index),
        .seed_value (seed_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value)
    );

    dx_k_s_mrg_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .seed_index (seed_index),
        .seed_value (seed_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Hard stop well beyond the slowest legal run (several times over).
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: mix stall bursts at random with open stretches,
    // drop all stalls once the calm phase starts.
    initial
    begin : result_sink
        @(posedge rst_n);
        forever
        begin
            if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Present one input word and hold it until the block takes it. Now and
    // then drop valid for a burst first, so gaps land on every phase of a step.
    task automatic send_word(input cmd_t cmd, input logic [SEED_IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] val);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        seed_index <= idx;
        seed_value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic load_word(input logic [SEED_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        send_word(CMD_LOAD, idx, val);
        seeded[idx] = 1'b1;
    endtask

    // Step the generator. Seed the newest and oldest slots first if they were
    // never written; the step then defines the slot it overwrites.
    task automatic step_word();
        int unsigned next_slot;
        next_slot = (cursor + 1 >= ring_span) ? 0 : cursor + 1;
        if (!seeded[cursor])
            load_word(SEED_IDX_W'(cursor), WORD_W'($urandom));
        if (!seeded[next_slot])
            load_word(SEED_IDX_W'(next_slot), WORD_W'($urandom));
        // seed fields are don't-care on a step: randomize them anyway
        send_word(CMD_STEP, SEED_IDX_W'($urandom), WORD_W'($urandom));
        seeded[next_slot] = 1'b1;
        cursor = next_slot;
    endtask

    // Hold off the sender until every expected result has come back, then
    // give the block its step latency to settle. Pending is registered, so
    // step past the next edge before polling.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Write all four registers back to back; call only while idle.
    task automatic set_config(input logic [ORD_W-1:0] ord, input logic [WORD_W-1:0] mult,
                              input logic [WORD_W-1:0] modulus, input logic [VAR_W-1:0] mode);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ORDER;
        cfg_data  <= CFG_DATA_W'(ord);
        @(posedge clk);
        cfg_index <= REG_MULT;
        cfg_data  <= mult;
        @(posedge clk);
        cfg_index <= REG_MOD;
        cfg_data  <= modulus;
        @(posedge clk);
        cfg_index <= REG_VARIANT;
        cfg_data  <= CFG_DATA_W'(mode);
        @(posedge clk);
        cfg_we <= 1'b0;
        ring_span = (ord < 2) ? 2 : (ord > MAX_ORDER) ? MAX_ORDER : int'(ord);
    endtask

    // Mostly steps (the recurrence is where the work is), with random seed
    // overwrites anywhere in the ring mixed in.
    task automatic run_phase(input int unsigned count);
        repeat (count)
        begin
            if ($urandom_range(0, 4) == 0)
                load_word(SEED_IDX_W'($urandom), WORD_W'($urandom));
            else
                step_word();
        end
    endtask

    initial
    begin : stimulus
        logic [ORD_W-1:0]  ord;
        logic [WORD_W-1:0] mult;
        logic [WORD_W-1:0] modulus;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: seeds at both ends of the index range, a seed at
        // the top of the field (not below the modulus), and a zero seed.
        load_word(SEED_IDX_W'(0), 31'h7FFF_FFFF);
        load_word(SEED_IDX_W'(1), 31'h0);
        load_word(SEED_IDX_W'(1023), 31'h7FFF_FFFE);
        repeat (3) step_word();
        drain();

        // Order below range, multiplier at the field top, modulus zero,
        // unknown variant zero.
        set_config(ORD_W'(0), 31'h7FFF_FFFF, 31'h0, VAR_W'(0));
        repeat (4) step_word();
        drain();

        // Order one, largest legal multiplier, modulus one, variant three.
        set_config(ORD_W'(1), 31'h7FFF_FFFE, 31'h1, VAR_W'(3));
        repeat (4) step_word();
        drain();

        // Largest order with the sum mode; run the position up the ring.
        set_config(ORD_W'(MAX_ORDER), 31'h7FFF_FFFE, 31'h7FFF_FFFF, VARIANT_SUM);
        repeat (6) step_word();
        drain();

        // Lower the order below the running position: the next step wraps.
        set_config(ORD_W'(3), 31'd48271, 31'h7FFF_FFFF, VARIANT_SUM);
        repeat (4) step_word();
        drain();

        // Random phases; the last one runs with no idling on either side.
        for (int phase = 0; phase < 12; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       ord = ORD_W'(MAX_ORDER);
                1:       ord = 11'h7FF;
                2:       ord = ORD_W'($urandom);
                default: ord = ORD_W'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 5))
                0:       mult = 31'h1;
                1:       mult = 31'h7FFF_FFFE;
                2:       mult = 31'h0;
                default: mult = WORD_W'($urandom);
            endcase
            case ($urandom_range(0, 6))
                0:       modulus = 31'h2;
                1:       modulus = 31'h7FFF_FFFF;
                2:       modulus = WORD_W'($urandom_range(0, 1));
                3:       modulus = WORD_W'($urandom_range(3, 1000));
                default: modulus = WORD_W'($urandom);
            endcase
            if (phase == 11)
                calm = 1'b1;
            set_config(ord, mult, modulus, VAR_W'($urandom_range(0, 3)));
            run_phase(80);
            drain();
        end

        // drain() above already waited out the step latency
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/dksm_pkg.sv
rtl/core/dksm_ring_mem.sv
rtl/core/dksm_mod_reduce.sv
rtl/core/dx_k_s_mrg_generator_core.sv
tb/sv/dx_k_s_mrg_result_checker.sv
tb/sv/dx_k_s_mrg_generator_core_tb.sv
